### hdl/bqw_pkg.sv
// ----------------------------------------------------------------------------
// bqw_pkg
// shared widths, constants and stage payload types of the bezier waveshaper
// ----------------------------------------------------------------------------
package bqw_pkg;

   localparam int PHASE_W  = 16;
   localparam int WEIGHT_W = 16;
   localparam int SAMPLE_W = 20;
   localparam int FRAC_W   = 14;
   localparam int U_W      = FRAC_W + 1;
   localparam int UV_W     = 27;
   localparam int UU_W     = 29;
   localparam int UVV_W    = UV_W + U_W;
   localparam int UUU_W    = UU_W + U_W;
   localparam int UUY_W    = UU_W + 1 + WEIGHT_W;
   localparam int UVVX_W   = UVV_W + 1 + WEIGHT_W;
   localparam int UUUZ_W   = UUU_W + 1 + WEIGHT_W;
   localparam int UUY3_W   = UUY_W + 2;
   localparam int TERM_W   = 62;
   localparam int X_SHIFT  = 16;
   localparam int RND_LSB  = 42;
   localparam int NUM_STAGES = 7;

   localparam logic [U_W-1:0]           ONE_U       = U_W'(1 << FRAC_W);
   localparam logic signed [17:0]       HALF_PI_Q16 = 18'sd102944;
   localparam logic signed [TERM_W-1:0] ROUND_BIAS  = TERM_W'(64'sd1 <<< (RND_LSB - 1));

   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // products after the power stages
   typedef struct packed {
      logic [UVV_W-1:0]        uvv;
      logic [UUU_W-1:0]        uuu;
      logic signed [UUY_W-1:0] uuy;
      weight_type              weight_x;
      weight_type              weight_z;
      logic [1:0]              quad;
   } powers_type;

   // the three scaled terms at 2^-57
   typedef struct packed {
      logic signed [TERM_W-1:0] t1;
      logic signed [TERM_W-1:0] t2;
      logic signed [TERM_W-1:0] t3;
      logic [1:0]               quad;
   } terms_type;

endpackage

### hdl/bqw_req_if.sv
// ----------------------------------------------------------------------------
// bqw_req_if
// request channel: phase and three weights with valid/ready
// ----------------------------------------------------------------------------
interface bqw_req_if
   import bqw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PHASE_W-1:0]  phase;
   weight_type          weight_x;
   weight_type          weight_y;
   weight_type          weight_z;

   modport source (output valid, output phase, output weight_x, output weight_y,
                   output weight_z, input ready);
   modport sink   (input valid, input phase, input weight_x, input weight_y,
                   input weight_z, output ready);
endinterface

### hdl/bqw_rsp_if.sv
// ----------------------------------------------------------------------------
// bqw_rsp_if
// response channel: shaped sample with valid/ready
// ----------------------------------------------------------------------------
interface bqw_rsp_if
   import bqw_pkg::*;
();
   logic       valid;
   logic       ready;
   sample_type shaped_sample;

   modport source (output valid, output shaped_sample, input ready);
   modport sink   (input valid, input shaped_sample, output ready);
endinterface

### hdl/bqw_powers.sv
// ----------------------------------------------------------------------------
// bqw_powers
// stages 1 to 3: u and v from the phase, then u*v*v, u^3 and u^2*y
// ----------------------------------------------------------------------------
module bqw_powers
   import bqw_pkg::*;
(
   input  logic               clock,
   input  logic [2:0]         en,
   input  logic [PHASE_W-1:0] phase,
   input  weight_type         weight_x,
   input  weight_type         weight_y,
   input  weight_type         weight_z,
   output powers_type         powers
);

   logic [U_W-1:0]          u1_ff, u1_in, v1_ff, v1_in;
   logic [1:0]              quad1_ff, quad2_ff, quad3_ff;
   weight_type              x1_ff, y1_ff, z1_ff, x2_ff, y2_ff, z2_ff, x3_ff, z3_ff;
   logic [U_W-1:0]          u2_ff, v2_ff;
   logic [UV_W-1:0]         uv2_ff, uv2_in;
   logic [UU_W-1:0]         uu2_ff, uu2_in;
   logic [UVV_W-1:0]        uvv3_ff, uvv3_in;
   logic [UUU_W-1:0]        uuu3_ff, uuu3_in;
   logic signed [UUY_W-1:0] uuy3_ff, uuy3_in;

   // odd quadrants count down
   always_comb begin
      if (phase[FRAC_W]) begin
         u1_in = ONE_U - U_W'(phase[FRAC_W-1:0]);
      end else begin
         u1_in = U_W'(phase[FRAC_W-1:0]);
      end
      v1_in = ONE_U - u1_in;
   end

   assign uv2_in  = UV_W'(u1_ff) * UV_W'(v1_ff);
   assign uu2_in  = UU_W'(u1_ff) * UU_W'(u1_ff);
   assign uvv3_in = UVV_W'(uv2_ff) * UVV_W'(v2_ff);
   assign uuu3_in = UUU_W'(uu2_ff) * UUU_W'(u2_ff);
   assign uuy3_in = UUY_W'($signed({1'b0, uu2_ff})) * UUY_W'(y2_ff);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u1_ff    <= u1_in;
         v1_ff    <= v1_in;
         quad1_ff <= phase[PHASE_W-1:FRAC_W];
         x1_ff    <= weight_x;
         y1_ff    <= weight_y;
         z1_ff    <= weight_z;
      end
      if (en[1]) begin
         uv2_ff   <= uv2_in;
         uu2_ff   <= uu2_in;
         u2_ff    <= u1_ff;
         v2_ff    <= v1_ff;
         quad2_ff <= quad1_ff;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
      end
      if (en[2]) begin
         uvv3_ff  <= uvv3_in;
         uuu3_ff  <= uuu3_in;
         uuy3_ff  <= uuy3_in;
         quad3_ff <= quad2_ff;
         x3_ff    <= x2_ff;
         z3_ff    <= z2_ff;
      end
   end

   assign powers.uvv      = uvv3_ff;
   assign powers.uuu      = uuu3_ff;
   assign powers.uuy      = uuy3_ff;
   assign powers.weight_x = x3_ff;
   assign powers.weight_z = z3_ff;
   assign powers.quad     = quad3_ff;

endmodule

### hdl/bqw_terms.sv
// ----------------------------------------------------------------------------
// bqw_terms
// stages 4 and 5: weight products and scaling of the three terms to 2^-57
// ----------------------------------------------------------------------------
module bqw_terms
   import bqw_pkg::*;
(
   input  logic       clock,
   input  logic [1:0] en,
   input  powers_type powers,
   output terms_type  terms
);

   logic signed [UVVX_W-1:0] uvvx4_ff, uvvx4_in;
   logic signed [UUUZ_W-1:0] uuuz4_ff, uuuz4_in;
   logic signed [UUY3_W-1:0] uuy3x;
   logic signed [TERM_W-1:0] t2_4_ff, t2_4_in;
   logic [1:0]               quad4_ff;
   terms_type                terms5_ff, terms5_in;

   assign uvvx4_in = UVVX_W'($signed({1'b0, powers.uvv})) * UVVX_W'(powers.weight_x);
   assign uuuz4_in = UUUZ_W'($signed({1'b0, powers.uuu})) * UUUZ_W'(powers.weight_z);

   // 3*u^2*y scaled by 2^14
   assign uuy3x   = UUY3_W'($signed({powers.uuy, 1'b0})) + UUY3_W'(powers.uuy);
   assign t2_4_in = TERM_W'($signed({uuy3x, 14'b0}));

   always_comb begin
      // floor by 2^16, then pi/2 in Q16
      terms5_in.t1   = TERM_W'($signed(uvvx4_ff[UVVX_W-1:X_SHIFT])) * TERM_W'(HALF_PI_Q16);
      terms5_in.t2   = t2_4_ff;
      terms5_in.t3   = -TERM_W'($signed({uuuz4_ff, 1'b0}));
      terms5_in.quad = quad4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         uvvx4_ff <= uvvx4_in;
         uuuz4_ff <= uuuz4_in;
         t2_4_ff  <= t2_4_in;
         quad4_ff <= powers.quad;
      end
      if (en[1]) begin
         terms5_ff <= terms5_in;
      end
   end

   assign terms = terms5_ff;

endmodule

### hdl/bqw_round.sv
// ----------------------------------------------------------------------------
// bqw_round
// stages 6 and 7: sum with rounding bias, cut to q4.15, sign of second half
// ----------------------------------------------------------------------------
module bqw_round
   import bqw_pkg::*;
(
   input  logic       clock,
   input  logic [1:0] en,
   input  terms_type  terms,
   output sample_type sample
);

   logic signed [TERM_W-1:0] sum6_ff, sum6_in;
   logic                     neg6_ff;
   sample_type               rnd, sample7_ff, sample7_in;

   assign sum6_in = terms.t1 + terms.t2 + terms.t3 + ROUND_BIAS;

   // the rounded value always fits the sample width
   assign rnd = $signed(sum6_ff[RND_LSB+SAMPLE_W-1:RND_LSB]);

   always_comb begin
      if (neg6_ff) begin
         sample7_in = -rnd;
      end else begin
         sample7_in = rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sum6_ff <= sum6_in;
         neg6_ff <= terms.quad[1];
      end
      if (en[1]) begin
         sample7_ff <= sample7_in;
      end
   end

   assign sample = sample7_ff;

endmodule

### hdl/bezier_quadrant_waveshaper_unit.sv
// ----------------------------------------------------------------------------
// bezier_quadrant_waveshaper_unit
// quadrant bezier waveshaper: one shaped q4.15 sample per phase/weight set
// ----------------------------------------------------------------------------
// usage
//   req_chan carries a transaction of phase (u0.16) and weights x, y, z (q1.15)
//   rsp_chan returns one shaped_sample (q4.15) per request, in request order
//   seven register stages: a request passes through stages 1 to 6 into
//   the output register, stage 7, and is taken when rsp_chan.ready is high
//   throughput is one transaction per cycle while rsp_chan does not stall,
//   set by the seven-stage pipeline with no feedback; every stage holds at
//   most one transaction
//   each stage has its own valid bit and advances when the next stage is empty
//   or moves, so bubbles close up and req_chan.ready stays high while any
//   stage is free, also when a finished sample waits on rsp_chan
//   when rsp_chan stalls with all stages full, req_chan.ready drops; nothing
//   is lost or repeated
//   reset clears the valid bits only; data registers need no reset
//   stage split: u/v, u*v and u^2, cubic powers and u^2*y, weight products,
//   term scaling, sum with rounding bias, cut and second-half negate
// ----------------------------------------------------------------------------
module bezier_quadrant_waveshaper_unit
   import bqw_pkg::*;
(
   input logic         clock,
   input logic         reset,
   bqw_req_if.sink     req_chan,
   bqw_rsp_if.source   rsp_chan
);

   logic [NUM_STAGES:1] valid_ff, valid_in;
   logic [NUM_STAGES:1] en;
   powers_type          powers;
   terms_type           terms;
   sample_type          sample;
   logic                req_xact, rsp_xact;

   // stage enables: load when empty or when the stage below moves on
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_chan.ready;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   // valid bits follow their data
   always_comb begin
      valid_in[1] = en[1] ? req_chan.valid : valid_ff[1];
      for (int i = 2; i <= NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = en[1];
   assign req_xact       = req_chan.valid && req_chan.ready;
   assign rsp_xact       = rsp_chan.valid && rsp_chan.ready;

   // stages 1 to 3
   bqw_powers u_powers (
      .clock    (clock),
      .en       (en[3:1]),
      .phase    (req_chan.phase),
      .weight_x (req_chan.weight_x),
      .weight_y (req_chan.weight_y),
      .weight_z (req_chan.weight_z),
      .powers   (powers)
   );

   // stages 4 and 5
   bqw_terms u_terms (
      .clock  (clock),
      .en     (en[5:4]),
      .powers (powers),
      .terms  (terms)
   );

   // stages 6 and 7, stage 7 is the output register
   bqw_round u_round (
      .clock  (clock),
      .en     (en[7:6]),
      .terms  (terms),
      .sample (sample)
   );

   assign rsp_chan.valid         = valid_ff[NUM_STAGES];
   assign rsp_chan.shaped_sample = sample;

   // occupancy moves only by accepted requests and taken responses
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ($countones(valid_ff) == $past($countones(valid_ff))
            + $past(32'(req_xact)) - $past(32'(rsp_xact))))
      else $error("pipeline occupancy mismatch");

   // a free stage anywhere means the request side is open
   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != '1) |-> req_chan.ready)
      else $error("request stalled with a free stage");

   // a stalled output holds its sample
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (rsp_chan.valid && $stable(sample)))
      else $error("stalled output sample changed");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
